@@ design/write_ahead_log_controller_top_defines.svh @@
// Assertion macros shared by the write-ahead log controller RTL.
// No dependencies; files that check behavior include this header by name.
`ifndef WRITE_AHEAD_LOG_CONTROLLER_TOP_DEFINES_SVH
`define WRITE_AHEAD_LOG_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clk edge outside reset.
`define WALC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("walc: assertion failed");
// Condition that must never be seen outside reset.
`define WALC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("walc: forbidden condition seen");
`else
`define WALC_ASSERT(lbl, prop)
`define WALC_NEVER(lbl, expr)
`endif
`endif

@@ design/walc_pkg.sv @@
// Shared types, codes and constants of the write-ahead log controller.
// No dependencies.
`default_nettype none

package walc_pkg;

  localparam int LOG_ENTRIES       = 30;
  localparam int OP_RESERVE_BLOCKS = 10;
  localparam int MAX_OPEN          = 3;

  localparam int BLK_W  = 32;
  localparam int IDX_W  = 5;              // slot index / entry count width
  localparam int SIZE_W = 5;
  localparam int NEED_W = 8;              // entry count plus reservations

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_END   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_WAIT      = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_OP     = 3'd3,
    ST_END_NO_OP = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_COPY    = 2'd1,
    CMD_HEADER  = 2'd2,
    CMD_INSTALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_INSTALL,
    S_CLOSE
  } state_t;

  typedef enum logic [0:0] {
    CFG_LOG_START = 1'b0,
    CFG_LOG_SIZE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t           status;
    cmd_t              command;
    logic [BLK_W-1:0]  src;
    logic [BLK_W-1:0]  dst;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cnt;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [BLK_W-1:0]  log_start;
    logic [SIZE_W-1:0] log_size;
  } cfg_t;

  function automatic res_t make_res(status_t st, cmd_t cmd, logic [BLK_W-1:0] src,
                                    logic [BLK_W-1:0] dst, logic [IDX_W-1:0] idx,
                                    logic [IDX_W-1:0] cnt, logic last);
    res_t r;
    r.status  = st;
    r.command = cmd;
    r.src     = src;
    r.dst     = dst;
    r.idx     = idx;
    r.cnt     = cnt;
    r.last    = last;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/walc_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module walc_ram #(
  parameter int DEPTH  = 30,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/walc_ctrl.sv @@
// Sequencer of the write-ahead log controller: admission, slot search, commit.
// Depends on walc_pkg and the assertion macro header; drives the home-block RAM.
`default_nettype none
`include "write_ahead_log_controller_top_defines.svh"

module walc_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     op,
  input  wire logic [walc_pkg::BLK_W-1:0]     blk,
  input  wire walc_pkg::cfg_t                 cfg,
  output logic                                ram_we,
  output logic [walc_pkg::IDX_W-1:0]          ram_waddr,
  output logic [walc_pkg::BLK_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [walc_pkg::IDX_W-1:0]          ram_raddr,
  input  wire logic [walc_pkg::BLK_W-1:0]     ram_rdata,
  output logic                                res_vld,
  output walc_pkg::res_t                      res
);

  import walc_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] ec_r, ec_nxt;
  logic [1:0]       open_r, open_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             vld_r, vld_nxt;
  res_t             res_r, res_nxt;

  logic [NEED_W-1:0] need;
  logic              full;
  logic              at_end;
  logic [BLK_W-1:0]  slot_blk;
  logic [IDX_W-1:0]  ptr_inc;

  assign need = NEED_W'(ec_r)
              + NEED_W'({1'b0, open_r} + 3'd1) * NEED_W'(OP_RESERVE_BLOCKS);
  // log_size below 2 always reads as full
  assign full = (ec_r >= IDX_W'(LOG_ENTRIES))
             || (({1'b0, ec_r} + 6'd1) >= {1'b0, cfg.log_size});
  assign at_end   = (({1'b0, ptr_r} + 6'd1) == {1'b0, ec_r});
  assign slot_blk = cfg.log_start + BLK_W'(ptr_r) + 32'd1;
  assign ptr_inc  = ptr_r + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ec_r    <= '0;
      open_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ec_r    <= ec_nxt;
      open_r  <= open_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    blk_r <= blk_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    ec_nxt    = ec_r;
    open_nxt  = open_r;
    blk_nxt   = blk_r;
    vld_nxt   = 1'b0;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = ec_r;
    ram_wdata = blk_r;
    ram_re    = 1'b0;
    ram_raddr = ptr_inc;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          vld_nxt = 1'b1;
          res_nxt = make_res(ST_OK, CMD_NONE, '0, '0, '0, '0, 1'b1);
          case (op)
            OP_BEGIN: begin
              if ((open_r == 2'(MAX_OPEN)) || (need > NEED_W'(LOG_ENTRIES))) begin
                res_nxt.status = ST_WAIT;
              end else begin
                open_nxt = open_r + 2'd1;
              end
            end
            OP_WRITE: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else if (open_r == 2'd0) begin
                res_nxt.status = ST_NO_OP;
              end else if (ec_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = blk;
                ec_nxt    = 5'd1;
                res_nxt   = make_res(ST_OK, CMD_COPY, '0, cfg.log_start + 32'd1,
                                     '0, '0, 1'b1);
              end else begin
                // walk the logged slots, one read per cycle
                vld_nxt   = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_nxt   = '0;
                blk_nxt   = blk;
                state_nxt = S_SEARCH;
              end
            end
            OP_END: begin
              if (open_r == 2'd0) begin
                res_nxt.status = ST_END_NO_OP;
              end else begin
                open_nxt = open_r - 2'd1;
                if ((open_r == 2'd1) && (ec_r != '0)) begin
                  res_nxt   = make_res(ST_OK, CMD_HEADER, '0, cfg.log_start, '0,
                                       ec_r, 1'b0);
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  ptr_nxt   = '0;
                  state_nxt = S_INSTALL;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        if (ram_rdata == blk_r) begin
          // absorbed: slot already holds this block
          vld_nxt   = 1'b1;
          res_nxt   = make_res(ST_OK, CMD_COPY, '0, slot_blk, ptr_r, '0, 1'b1);
          state_nxt = S_IDLE;
        end else if (at_end) begin
          ram_we    = 1'b1;
          ram_waddr = ec_r;
          ram_wdata = blk_r;
          ec_nxt    = ec_r + 5'd1;
          vld_nxt   = 1'b1;
          res_nxt   = make_res(ST_OK, CMD_COPY, '0,
                               cfg.log_start + BLK_W'(ec_r) + 32'd1, ec_r, '0, 1'b1);
          state_nxt = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          ptr_nxt = ptr_inc;
        end
      end

      S_INSTALL: begin
        vld_nxt = 1'b1;
        res_nxt = make_res(ST_OK, CMD_INSTALL, slot_blk, ram_rdata, ptr_r, '0, 1'b0);
        if (at_end) begin
          state_nxt = S_CLOSE;
        end else begin
          ram_re  = 1'b1;
          ptr_nxt = ptr_inc;
        end
      end

      S_CLOSE: begin
        vld_nxt   = 1'b1;
        res_nxt   = make_res(ST_OK, CMD_HEADER, '0, cfg.log_start, '0, '0, 1'b1);
        ec_nxt    = '0;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy    = (state_r != S_IDLE);
  assign res_vld = vld_r;
  assign res     = res_r;

  // every item other than a write answers on the next cycle
  `WALC_ASSERT(a_quick_result, (start && !busy && (op != OP_WRITE)) |=> vld_r)
  // back in idle with a result out means the item just finished
  `WALC_ASSERT(a_idle_last, (vld_r && (state_r == S_IDLE)) |-> res_r.last)
  `WALC_ASSERT(a_count_bound, ec_r <= IDX_W'(LOG_ENTRIES))
  // slot write and slot read never share a cycle
  `WALC_NEVER(a_no_rw_overlap, ram_we && ram_re)

endmodule

`default_nettype wire

@@ design/write_ahead_log_controller_top.sv @@
// Top level of the write-ahead log controller: configuration registers, home-block RAM
// and the sequencer. Depends on walc_pkg, walc_ram and walc_ctrl.
`default_nettype none

// Journaling controller with block absorption. An item (begin, write or end) is
// taken when start is high and busy is low; its results appear one per cycle on
// the out_ ports, each marked by out_valid for exactly one cycle, with out_last
// on the final one. The receiver cannot stall, so results must be taken as shown.
// Sequencing: begin, end without commit, errors and code 3 leave busy low, so the next
// item may follow at once. A write whose block sits in slot i holds busy while it reads
// slots 0 to i; a write that appends to n logged slots holds it while it reads all n
// (none when the log is empty). A commit of n slots emits n+2 results (header, n
// installs, closing header), up to 32. The single read port of the home-block RAM
// reads one slot per cycle.
// Configuration: cfg_ready is always high; write only while the block is idle.

module write_ahead_log_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_block_number,
  // result channel
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [1:0]       out_command,
  output logic [31:0]      out_source_block,
  output logic [31:0]      out_destination_block,
  output logic [4:0]       out_entry_index,
  output logic [4:0]       out_header_count,
  output logic             out_last,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import walc_pkg::*;

  cfg_t             cfg_r;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [BLK_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [BLK_W-1:0] ram_rdata;
  logic             res_vld;
  res_t             res;

  // register file: log header block and log length
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_start <= '0;
      cfg_r.log_size  <= SIZE_W'(31);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOG_START: cfg_r.log_start <= cfg_data;
        CFG_LOG_SIZE:  cfg_r.log_size  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // home block of every log slot; slots at or past the entry count are never read
  walc_ram #(
    .DEPTH  (LOG_ENTRIES),
    .WIDTH  (BLK_W),
    .ADDR_W (IDX_W)
  ) u_home_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  walc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (in_operation),
    .blk       (in_block_number),
    .cfg       (cfg_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_vld   (res_vld),
    .res       (res)
  );

  // results leave straight from the sequencer's output register
  assign out_valid             = res_vld;
  assign out_status            = res.status;
  assign out_command           = res.command;
  assign out_source_block      = res.src;
  assign out_destination_block = res.dst;
  assign out_entry_index       = res.idx;
  assign out_header_count      = res.cnt;
  assign out_last              = res.last;

endmodule

`default_nettype wire

@@ tb/sv/write_ahead_log_controller_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for write_ahead_log_controller_top: begin/write/end items go in,
// every journal command that should come out is predicted and compared field by field.
// Depends on walc_pkg and the controller RTL.

module write_ahead_log_controller_top_tb;
  import walc_pkg::*;

  // Margin after the longest stretch of busy or results, before touching
  // configuration and before the verdict.
  localparam int PAUSE_CYCLES = 40;
  // Cycles with no item, result or register write before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    op_t         op;
    logic [31:0] blk;
  } journal_op_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic [1:0]  in_operation    = OP_NOP;
  logic [31:0] in_block_number = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [1:0]  out_command;
  logic [31:0] out_source_block;
  logic [31:0] out_destination_block;
  logic [4:0]  out_entry_index;
  logic [4:0]  out_header_count;
  logic        out_last;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index       = CFG_LOG_START;
  logic [31:0] cfg_data        = '0;

  write_ahead_log_controller_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_block_number       (in_block_number),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_command           (out_command),
    .out_source_block      (out_source_block),
    .out_destination_block (out_destination_block),
    .out_entry_index       (out_entry_index),
    .out_header_count      (out_header_count),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Journal mirror: registers, logged home blocks, open operation count
  // ---------------------------------------------------------------------------------------
  logic [31:0] log_start_q = '0;
  logic [4:0]  log_size_q  = 5'd31;
  logic [31:0] slot_home [LOG_ENTRIES];
  int          logged_n    = 0;
  int          open_n      = 0;

  res_t        log_cmds_due [$];   // commands the controller still owes us, oldest first
  res_t        observed     [$];   // results sampled at the edge, compared off the edge
  journal_op_t ops_backlog  [$];   // items waiting for the driver
  bit          gaps_on      = 1'b1;
  int          errors       = 0;
  int          quiet_cycles = 0;

  task automatic post(status_t st, cmd_t cmd, logic [31:0] src, logic [31:0] dst,
                      logic [4:0] idx, logic [4:0] cnt, logic last);
    res_t r;
    r.status  = st;
    r.command = cmd;
    r.src     = src;
    r.dst     = dst;
    r.idx     = idx;
    r.cnt     = cnt;
    r.last    = last;
    log_cmds_due.push_back(r);
  endtask

  // Advances the mirror by one accepted item and queues the commands it causes.
  task automatic journal_step(op_t op, logic [31:0] blk);
    int slot;
    slot = 0;
    case (op)
      OP_BEGIN: begin
        // Grant only if every open operation, the new one too, can still log its worst case.
        if (open_n >= MAX_OPEN ||
            logged_n + (open_n + 1) * OP_RESERVE_BLOCKS > LOG_ENTRIES) begin
          post(ST_WAIT, CMD_NONE, '0, '0, '0, '0, 1'b1);
        end else begin
          open_n++;
          post(ST_OK, CMD_NONE, '0, '0, '0, '0, 1'b1);
        end
      end
      OP_WRITE: begin
        // Full check wins over the no-operation check.
        if (logged_n >= LOG_ENTRIES || log_size_q < 5'd2 ||
            logged_n >= int'(log_size_q) - 1) begin
          post(ST_FULL, CMD_NONE, '0, '0, '0, '0, 1'b1);
        end else if (open_n == 0) begin
          post(ST_NO_OP, CMD_NONE, '0, '0, '0, '0, 1'b1);
        end else begin
          // Absorption: reuse the slot already holding this home block.
          while (slot < logged_n && slot_home[slot] != blk) slot++;
          slot_home[slot] = blk;
          if (slot == logged_n) logged_n++;
          post(ST_OK, CMD_COPY, '0, log_start_q + 32'(slot) + 32'd1, 5'(slot), '0, 1'b1);
        end
      end
      OP_END: begin
        if (open_n == 0) begin
          post(ST_END_NO_OP, CMD_NONE, '0, '0, '0, '0, 1'b1);
        end else begin
          open_n--;
          if (open_n != 0 || logged_n == 0) begin
            post(ST_OK, CMD_NONE, '0, '0, '0, '0, 1'b1);
          end else begin
            // Commit: header with count, install every slot, header with zero.
            post(ST_OK, CMD_HEADER, '0, log_start_q, '0, 5'(logged_n), 1'b0);
            for (int i = 0; i < logged_n; i++)
              post(ST_OK, CMD_INSTALL, log_start_q + 32'(i) + 32'd1, slot_home[i],
                   5'(i), '0, 1'b0);
            post(ST_OK, CMD_HEADER, '0, log_start_q, '0, '0, 1'b1);
            logged_n = 0;
          end
        end
      end
      default: begin
        post(ST_OK, CMD_NONE, '0, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // Register mirror follows every accepted write on the config channel.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOG_START: log_start_q <= cfg_data;
        CFG_LOG_SIZE:  log_size_q  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Driver: present the next item whenever the current one was taken or none is up.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    journal_op_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        journal_step(op_t'(in_operation), in_block_number);
      end
      if (!start || !busy) begin
        // A gap with a chance of 9 in 100 unless this phase runs back to back.
        if (ops_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 9)) begin
          nxt = ops_backlog.pop_front();
          start           <= 1'b1;
          in_operation    <= nxt.op;
          in_block_number <= nxt.blk;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: sample at the rising edge, compare at the falling edge so the prediction for an
  // item taken on the same edge is already queued.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_valid) begin
      got.status  = status_t'(out_status);
      got.command = cmd_t'(out_command);
      got.src     = out_source_block;
      got.dst     = out_destination_block;
      got.idx     = out_entry_index;
      got.cnt     = out_header_count;
      got.last    = out_last;
      observed.push_back(got);
    end
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(negedge clk) begin : result_compare
    res_t got;
    res_t want;
    while (observed.size() != 0) begin
      got = observed.pop_front();
      if (log_cmds_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual status %0d cmd %0d",
                 $time, got.status, got.command);
      end else begin
        want = log_cmds_due.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("command", 32'(want.command), 32'(got.command));
        check_field("source_block", want.src, got.src);
        check_field("destination_block", want.dst, got.dst);
        check_field("entry_index", 32'(want.idx), 32'(got.idx));
        check_field("header_count", 32'(want.cnt), 32'(got.cnt));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Hang detection: count cycles in which nothing at all is accepted.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  task automatic queue_op(op_t op, logic [31:0] blk);
    journal_op_t j;
    j.op  = op;
    j.blk = blk;
    ops_backlog.push_back(j);
  endtask

  // Wait until the controller has nothing in flight, then let it sit a while.
  task automatic settle();
    do @(negedge clk);
    while (ops_backlog.size() != 0 || start || busy ||
           log_cmds_due.size() != 0 || observed.size() != 0);
    repeat (PAUSE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One operation group: nested begins, writes drawn from a small pool so blocks repeat
  // and get absorbed, and matching ends with some writes between them. Returns items.
  task automatic queue_txn(output int added);
    logic [31:0] pool [$];
    int          depth;
    int          writes;
    int          half;
    int          sel;
    sel    = $urandom_range(99);
    depth  = (sel < 60) ? 1 : (sel < 85) ? 2 : 3;
    writes = ($urandom_range(9) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 8);
    repeat ($urandom_range(1, 8)) begin
      sel = $urandom_range(7);
      pool.push_back(sel == 0 ? 32'h0 : sel == 1 ? 32'hFFFF_FFFF : $urandom);
    end
    half  = writes / 2;
    added = 2 * depth + writes;
    repeat (depth) queue_op(OP_BEGIN, $urandom);
    repeat (half) queue_op(OP_WRITE, pool[$urandom_range(pool.size() - 1)]);
    queue_op(OP_END, $urandom);
    repeat (writes - half) queue_op(OP_WRITE, pool[$urandom_range(pool.size() - 1)]);
    repeat (depth - 1) queue_op(OP_END, $urandom);
  endtask

  // Mostly well-formed groups; the rest single random items, code 3 included.
  task automatic random_phase(int n_items, bit gaps);
    int queued;
    int added;
    queued  = 0;
    gaps_on = gaps;
    while (queued < n_items) begin
      if ($urandom_range(99) < 80) begin
        queue_txn(added);
        queued += added;
      end else begin
        queue_op(op_t'($urandom_range(3)), $urandom);
        queued++;
      end
    end
    settle();
  endtask

  initial begin
    logic [31:0] base;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: start 0, size 31. Error paths, nesting, absorption, commit.
    queue_op(OP_END, 32'hFFFF_FFFF);        // end without begin
    queue_op(OP_WRITE, 32'hFFFF_FFFF);      // write with nothing open
    queue_op(OP_NOP, 32'hFFFF_FFFF);        // code 3 ignored
    queue_op(OP_BEGIN, 32'h0);
    queue_op(OP_BEGIN, $urandom);
    queue_op(OP_BEGIN, $urandom);           // three open, reservations fill the log
    queue_op(OP_BEGIN, $urandom);           // open count at its top: must wait
    queue_op(OP_WRITE, 32'h0);
    queue_op(OP_WRITE, 32'hFFFF_FFFF);
    queue_op(OP_WRITE, 32'h0);              // absorbed into slot 0
    queue_op(OP_END, $urandom);             // others still open
    queue_op(OP_END, $urandom);
    queue_op(OP_END, $urandom);             // last one closes: commit of two slots
    queue_op(OP_BEGIN, $urandom);
    queue_op(OP_END, $urandom);             // closes with empty log: nothing to commit
    settle();

    // Smallest log, header near the top of the block range.
    set_reg(CFG_LOG_START, 32'hFFFF_FFF0);
    set_reg(CFG_LOG_SIZE, 32'd2);
    @(negedge clk);
    queue_op(OP_BEGIN, $urandom);
    queue_op(OP_WRITE, 32'h5);
    queue_op(OP_WRITE, 32'h7);              // log full
    queue_op(OP_WRITE, 32'h5);              // full even though it would absorb
    queue_op(OP_BEGIN, $urandom);
    queue_op(OP_END, $urandom);
    queue_op(OP_END, $urandom);             // one-slot commit
    settle();

    // Largest commit: 30 distinct blocks, one more is refused, then 32 commands.
    set_reg(CFG_LOG_START, 32'hFFFF_FFFF);
    set_reg(CFG_LOG_SIZE, 32'd31);
    @(negedge clk);
    base = $urandom;
    queue_op(OP_BEGIN, $urandom);
    for (int k = 0; k < 31; k++) queue_op(OP_WRITE, base + 32'(k));
    queue_op(OP_BEGIN, $urandom);           // no room for another reservation
    queue_op(OP_END, $urandom);
    settle();

    set_reg(CFG_LOG_START, $urandom);
    set_reg(CFG_LOG_SIZE, 32'($urandom_range(2, 31)));
    random_phase(30, 1'b1);

    // Back to back, no gaps at all.
    set_reg(CFG_LOG_START, 32'h0);
    set_reg(CFG_LOG_SIZE, 32'd31);
    random_phase(40, 1'b0);

    set_reg(CFG_LOG_START, $urandom);
    set_reg(CFG_LOG_SIZE, 32'($urandom_range(2, 31)));
    random_phase(30, 1'b1);

    set_reg(CFG_LOG_START, $urandom);
    set_reg(CFG_LOG_SIZE, 32'd31);
    random_phase(30, 1'b1);

    // Tiny logs: mostly full refusals and short commits.
    set_reg(CFG_LOG_START, $urandom);
    set_reg(CFG_LOG_SIZE, 32'($urandom_range(2, 6)));
    random_phase(25, 1'b1);

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
